### design/lin_style_frame_receiver_unit_defines.svh
// assertion macros used by the frame receiver port checker
`ifndef LIN_STYLE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define LIN_STYLE_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LSFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lsfr_pkg.sv
// types, constants and the crc function of the lin style frame receiver
package lsfr_pkg;

    localparam int COUNT_W            = 4;
    localparam int FLAGS_W            = 2;
    localparam int BYTE_W             = 8;
    localparam int DATA_W             = 64;
    localparam int NUM_LANES          = DATA_W / BYTE_W;
    localparam int TIMER_W            = 16;
    localparam int EVENT_W            = 3;
    localparam int RESPONSE_BYTES_DEF = 8;

    localparam logic [TIMER_W-1:0] IDLE_TIMEOUT_RST = 16'd100;
    localparam logic [BYTE_W-1:0]  CRC_POLY         = 8'h8C;
    localparam logic [COUNT_W-1:0] HEADER_LEN       = 4'd4;

    // input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_HEADER   = 3'd1,
        EV_RESP_OK  = 3'd2,
        EV_RESP_ERR = 3'd3,
        EV_TIMEOUT  = 3'd4
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic [BYTE_W-1:0]  frame_id;
        logic [DATA_W-1:0]  response_data;
        logic [BYTE_W-1:0]  computed_crc;
    } t_result;

    // reflected crc-8 update over one byte, lsb first
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
        logic              fb;
        c = crc;
        d = data;
        for (int k = 0; k < BYTE_W; k++) begin
            fb = c[0] ^ d[0];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

### design/lsfr_in_if.sv
// input channel: received byte or timer tick
interface lsfr_in_if
    import lsfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

### design/lsfr_out_if.sv
// result channel: event with frame id, response data and crc
interface lsfr_out_if
    import lsfr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  frame_id;
    logic [DATA_W-1:0]  response_data;
    logic [BYTE_W-1:0]  computed_crc;

    modport source (output valid, output event_res, output frame_id, output response_data,
                    output computed_crc, input ready);
    modport sink   (input valid, input event_res, input frame_id, input response_data,
                    input computed_crc, output ready);
endinterface

### design/lsfr_core.sv
// frame state, running crc, idle timer and per-item result logic
module lsfr_core
    import lsfr_pkg::*;
#(
    parameter int RESPONSE_BYTES = RESPONSE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TIMER_W-1:0] i_cfg_wdata,
    input  logic               i_step,
    input  logic               i_command,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output t_result            o_result
);

    localparam logic [COUNT_W-1:0] RESP_LEN  = COUNT_W'(RESPONSE_BYTES);
    localparam logic [COUNT_W-1:0] FRAME_LEN = COUNT_W'(RESPONSE_BYTES + 1);

    logic [TIMER_W-1:0] r_idle_timeout;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [FLAGS_W-1:0] r_first_zero, n_first_zero;
    logic [BYTE_W-1:0]  r_crc, n_crc;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [TIMER_W-1:0] r_idle_timer, n_idle_timer;
    logic               clear_frame;

    // next frame state and the result of this item
    always_comb begin
        n_byte_count = r_byte_count;
        n_first_zero = r_first_zero;
        n_crc        = r_crc;
        n_data       = r_data;
        n_idle_timer = r_idle_timer;
        clear_frame  = 1'b0;
        o_result     = '{event_res: EV_NONE, frame_id: '0, response_data: '0,
                         computed_crc: '0};
        if (i_step) begin
            if (i_command == CMD_BYTE) begin
                // leading zero flags for header detection
                if (r_byte_count == '0) begin
                    n_first_zero[0] = (i_rx_byte == '0);
                end else if (r_byte_count == COUNT_W'(1)) begin
                    n_first_zero[1] = (i_rx_byte == '0);
                end
                // data byte: store in its lane and fold into the crc
                if (r_byte_count < RESP_LEN) begin
                    n_crc = crc8_byte(r_crc, i_rx_byte);
                    for (int k = 0; k < NUM_LANES; k++) begin
                        if (k < RESPONSE_BYTES && r_byte_count == COUNT_W'(k)) begin
                            n_data[k*BYTE_W +: BYTE_W] = i_rx_byte;
                        end
                    end
                end
                n_byte_count = r_byte_count + COUNT_W'(1);
                n_idle_timer = '0;
                // frame completion
                if (n_byte_count == HEADER_LEN && n_first_zero == '1) begin
                    o_result.event_res = EV_HEADER;
                    o_result.frame_id  = i_rx_byte;
                    clear_frame        = 1'b1;
                end else if (n_first_zero != '1 && n_byte_count == FRAME_LEN) begin
                    o_result.event_res     = (i_rx_byte == n_crc) ? EV_RESP_OK : EV_RESP_ERR;
                    o_result.response_data = n_data;
                    o_result.computed_crc  = n_crc;
                    clear_frame            = 1'b1;
                end
            end else begin
                // saturating idle timer and timeout discard
                if (r_idle_timer != '1) begin
                    n_idle_timer = r_idle_timer + TIMER_W'(1);
                end
                if (r_byte_count != '0 && n_idle_timer > r_idle_timeout) begin
                    o_result.event_res = EV_TIMEOUT;
                    clear_frame        = 1'b1;
                end
            end
        end
        if (clear_frame) begin
            n_byte_count = '0;
            n_first_zero = '0;
            n_crc        = '0;
            n_data       = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= IDLE_TIMEOUT_RST;
            r_byte_count   <= '0;
            r_first_zero   <= '0;
            r_crc          <= '0;
            r_data         <= '0;
            r_idle_timer   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_idle_timeout <= i_cfg_wdata;
            end
            r_byte_count <= n_byte_count;
            r_first_zero <= n_first_zero;
            r_crc        <= n_crc;
            r_data       <= n_data;
            r_idle_timer <= n_idle_timer;
        end
    end

endmodule

### design/lsfr_out_buf.sv
// two-entry result buffer: output register plus skid register
module lsfr_out_buf
    import lsfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // buffer next state
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

### design/lin_style_frame_receiver_unit.sv
// top level of the lin style frame receiver
// Takes one item per clock while ready is high: a received byte or a timer tick, and
// returns exactly one result per item. A header is four bytes whose first two are zero
// and reports the fourth byte as frame id; otherwise RESPONSE_BYTES data bytes and a
// check byte end a response, checked against a reflected crc-8 (poly 0x8C) that is
// updated one whole byte per cycle while bytes are accepted. Ticks advance a saturating
// idle timer and discard a partial frame once it exceeds idle_timeout (reset 100). A
// two-entry result buffer keeps input transfers going while a result is stalled; input
// ready drops only when both entries are full. No clearing pass is needed after reset.
module lin_style_frame_receiver_unit
    import lsfr_pkg::*;
#(
    parameter int RESPONSE_BYTES = RESPONSE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TIMER_W-1:0] i_cfg_wdata,
    lsfr_in_if.sink            i_rx,
    lsfr_out_if.source         o_res
);

    logic    buf_ready;
    logic    in_xfer;
    t_result core_result;
    t_result out_result;

    assign i_rx.ready = buf_ready;
    assign in_xfer    = i_rx.valid && buf_ready;

    // per-item frame logic
    lsfr_core #(
        .RESPONSE_BYTES(RESPONSE_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_step     (in_xfer),
        .i_command  (i_rx.command),
        .i_rx_byte  (i_rx.rx_byte),
        .o_result   (core_result)
    );

    // result buffer
    lsfr_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (in_xfer),
        .i_data (core_result),
        .o_ready(buf_ready),
        .o_valid(o_res.valid),
        .o_data (out_result),
        .i_ready(o_res.ready)
    );

    // result payload onto the channel
    assign o_res.event_res     = out_result.event_res;
    assign o_res.frame_id      = out_result.frame_id;
    assign o_res.response_data = out_result.response_data;
    assign o_res.computed_crc  = out_result.computed_crc;

endmodule

### design/lsfr_checker.sv
// port-level assertions for the frame receiver and their bind
`include "lin_style_frame_receiver_unit_defines.svh"

module lsfr_checker
    import lsfr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [EVENT_W-1:0] i_event_res,
    input logic [BYTE_W-1:0]  i_frame_id,
    input logic [DATA_W-1:0]  i_response_data,
    input logic [BYTE_W-1:0]  i_computed_crc
);

    // a stalled result keeps its event
    `LSFR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_event_res), "stalled result changed")

    // every input transfer leaves a result waiting in the next cycle
    `LSFR_ASSERT_NEXT(a_xfer_result, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "input transfer without a result")

    // frame id only with a header event
    `LSFR_ASSERT_NOW(a_id_zero, i_clk, i_rst_n, i_out_valid && i_event_res != EV_HEADER, i_frame_id == '0, "frame id outside a header")

    // data and crc only with response events
    `LSFR_ASSERT_NOW(a_resp_zero, i_clk, i_rst_n, i_out_valid && i_event_res != EV_RESP_OK && i_event_res != EV_RESP_ERR, i_response_data == '0 && i_computed_crc == '0, "response fields outside a response")

endmodule

bind lin_style_frame_receiver_unit lsfr_checker u_lsfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_rx.valid),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_event_res    (o_res.event_res),
    .i_frame_id     (o_res.frame_id),
    .i_response_data(o_res.response_data),
    .i_computed_crc (o_res.computed_crc)
);

### verif/lsfr_tb_pkg.sv
// crc helper shared by the frame receiver testbench and its checker
package lsfr_tb_pkg;
    import lsfr_pkg::*;

    // reflected crc-8: fold the whole byte in, then shift it out lsb first
    function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] din);
        logic [BYTE_W-1:0] c;
        c = acc ^ din;
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### verif/lsfr_result_checker.sv
// checker that predicts every frame receiver result and compares it on the result channel
module lsfr_result_checker
    import lsfr_pkg::*, lsfr_tb_pkg::*;
#(
    parameter int RESPONSE_BYTES = RESPONSE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TIMER_W-1:0] i_cfg_wdata,
    lsfr_in_if                 i_rx_mon,
    lsfr_out_if                i_res_mon,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 MAX_PRINTS     = 40;
    localparam logic [FLAGS_W-1:0] BOTH_LEAD_ZERO = 2'b11;

    // predicted receiver state
    logic [COUNT_W-1:0] frame_len;
    logic [FLAGS_W-1:0] lead_zero;
    logic [BYTE_W-1:0]  crc_acc;
    logic [DATA_W-1:0]  data_acc;
    logic [TIMER_W-1:0] silence;
    logic [TIMER_W-1:0] timeout_cfg;

    t_result expected_q[$];
    int      fail_cnt   = 0;
    int      result_idx = 0;

    // drop the frame collected so far
    function automatic void clear_frame();
        frame_len = '0;
        lead_zero = '0;
        crc_acc   = '0;
        data_acc  = '0;
    endfunction

    // advance the predicted state by one input transfer and return its result
    function automatic t_result next_result(input logic cmd, input logic [BYTE_W-1:0] b);
        t_result            r;
        logic [COUNT_W-1:0] pos;
        r.event_res     = EV_NONE;
        r.frame_id      = '0;
        r.response_data = '0;
        r.computed_crc  = '0;
        if (cmd == CMD_BYTE) begin
            pos = frame_len;
            if (pos == 0) begin
                lead_zero[0] = (b == '0);
            end else if (pos == 1) begin
                lead_zero[1] = (b == '0);
            end
            if (int'(pos) < RESPONSE_BYTES && int'(pos) < NUM_LANES) begin
                data_acc = data_acc | (DATA_W'(b) << (BYTE_W * pos));
                crc_acc  = crc_fold(crc_acc, b);
            end
            frame_len = pos + 1'b1;
            silence   = '0;
            if (frame_len == HEADER_LEN && lead_zero == BOTH_LEAD_ZERO) begin
                r.event_res = EV_HEADER;
                r.frame_id  = b;
                clear_frame();
            end else if (lead_zero != BOTH_LEAD_ZERO && frame_len >= 2 &&
                         int'(frame_len) == RESPONSE_BYTES + 1) begin
                r.event_res     = (b == crc_acc) ? EV_RESP_OK : EV_RESP_ERR;
                r.response_data = data_acc;
                r.computed_crc  = crc_acc;
                clear_frame();
            end
        end else begin
            // saturating idle timer
            if (silence != '1) begin
                silence = silence + 1'b1;
            end
            if (frame_len != 0 && silence > timeout_cfg) begin
                r.event_res = EV_TIMEOUT;
                clear_frame();
            end
        end
        return r;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (fail_cnt < MAX_PRINTS) begin
            $display("lsfr_chk: result %0d: %s: got %0h, expected %0h",
                     result_idx, what, got, want);
        end
        fail_cnt++;
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_frame();
            silence     = '0;
            timeout_cfg = IDLE_TIMEOUT_RST;
            expected_q.delete();
        end else begin
            // result transfer against the oldest prediction
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing predicted", i_res_mon.event_res, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_res_mon.event_res !== want.event_res) begin
                        report_mismatch("event_res", i_res_mon.event_res, want.event_res);
                    end
                    if (i_res_mon.frame_id !== want.frame_id) begin
                        report_mismatch("frame_id", i_res_mon.frame_id, want.frame_id);
                    end
                    if (i_res_mon.response_data !== want.response_data) begin
                        report_mismatch("response_data", i_res_mon.response_data,
                                        want.response_data);
                    end
                    if (i_res_mon.computed_crc !== want.computed_crc) begin
                        report_mismatch("computed_crc", i_res_mon.computed_crc,
                                        want.computed_crc);
                    end
                end
                result_idx++;
            end
            // input transfer
            if (i_rx_mon.valid && i_rx_mon.ready) begin
                expected_q.push_back(next_result(i_rx_mon.command, i_rx_mon.rx_byte));
            end
            // register write
            if (i_cfg_we) begin
                timeout_cfg = i_cfg_wdata;
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_q.size();
    end

endmodule

### verif/tb_lin_style_frame_receiver_unit.sv
// testbench top: drives the frame receiver with frames, ticks and timeout settings
module tb_lin_style_frame_receiver_unit
    import lsfr_pkg::*, lsfr_tb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 CLK_PERIOD   = 12;
    localparam int                 RESET_CYCLES = 12;
    localparam int                 RESP_LEN     = RESPONSE_BYTES_DEF;
    localparam int                 RANDOM_ITEMS = 1300;
    localparam int                 NUM_PHASES   = 6;
    localparam int                 HOLD_CYCLES  = 400;
    localparam int                 TAIL_CYCLES  = 8;
    localparam int                 LIMIT_CYCLES = 2_000_000;
    localparam int                 MAX_TO_TICKS = 40;
    localparam logic [TIMER_W-1:0] TIMEOUT_MAX  = '1;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [TIMER_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 pending;

    bit                 hold_request   = 1'b0;
    bit                 sender_calm    = 1'b0;
    int                 items_sent     = 0;
    int                 headers_sent   = 0;
    int                 responses_sent = 0;
    int                 partials_sent  = 0;
    int                 settings_used  = 0;
    logic [TIMER_W-1:0] timeout_now;

    lsfr_in_if  rx_if();
    lsfr_out_if res_if();

    lin_style_frame_receiver_unit #(
        .RESPONSE_BYTES(RESP_LEN)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    lsfr_result_checker #(
        .RESPONSE_BYTES(RESP_LEN)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx_mon    (rx_if),
        .i_res_mon   (res_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(15, 4);
        return $urandom_range(90, 20);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    // byte with a strong bias toward zero, for the leading positions
    function automatic logic [BYTE_W-1:0] lead_byte();
        return ($urandom_range(2) == 0) ? BYTE_W'(0) : rand_byte();
    endfunction

    // response payload whose first two bytes are never both zero
    function automatic logic [DATA_W-1:0] random_data();
        logic [DATA_W-1:0] d;
        d = {$urandom, $urandom};
        for (int i = 0; i < 2; i++) begin
            if ($urandom_range(3) == 0) begin
                d[BYTE_W*i +: BYTE_W] = '0;
            end
        end
        if (d[2*BYTE_W-1:0] == '0) begin
            d[BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(255, 1));
        end
        return d;
    endfunction

    // one input transfer after an optional gap
    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.command <= cmd;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        items_sent++;
        if (items_sent % 100 == 0) begin
            sender_calm = ($urandom_range(3) == 0);
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(CMD_TICK, rand_byte());
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] sync, input logic [BYTE_W-1:0] id);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, sync);
        send_item(CMD_BYTE, id);
        headers_sent++;
    endtask

    // data bytes, then a check byte that matches the crc or is corrupted
    task automatic send_response(input logic [DATA_W-1:0] data, input bit good);
        logic [BYTE_W-1:0] crc;
        crc = '0;
        for (int i = 0; i < RESP_LEN; i++) begin
            crc = crc_fold(crc, data[BYTE_W*i +: BYTE_W]);
            send_item(CMD_BYTE, data[BYTE_W*i +: BYTE_W]);
        end
        send_item(CMD_BYTE, good ? crc : crc ^ BYTE_W'($urandom_range(255, 1)));
        responses_sent++;
    endtask

    // drop valid and wait until every predicted result has arrived
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [TIMER_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        timeout_now  = value;
        settings_used++;
    endtask

    // mostly well-formed frames, some cut off by silence, some noise
    task automatic random_phase(input int n_items);
        int stop_at;
        int kind;
        int n;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                send_header(rand_byte(), rand_byte());
            end else if (kind < 62) begin
                send_response(random_data(), $urandom_range(9) < 7);
            end else if (kind < 77) begin
                // partial frame, then silence around the timeout when it is small, short otherwise
                n = $urandom_range(RESP_LEN, 1);
                for (int i = 0; i < n; i++) begin
                    send_item(CMD_BYTE, (i < 2) ? lead_byte() : rand_byte());
                end
                partials_sent++;
                if (timeout_now <= 64) begin
                    send_ticks(int'(timeout_now) + int'($urandom_range(3)));
                end else begin
                    send_ticks($urandom_range(4, 1));
                end
            end else if (kind < 85) begin
                // frame with ticks in its middle
                n = $urandom_range(RESP_LEN, 1);
                for (int i = 0; i < n; i++) begin
                    send_item(CMD_BYTE, (i < 2) ? lead_byte() : rand_byte());
                end
                if (timeout_now <= 64) begin
                    send_ticks($urandom_range(int'(timeout_now) + 2, 1));
                end else begin
                    send_ticks($urandom_range(3, 1));
                end
                for (int i = n; i <= RESP_LEN; i++) begin
                    send_item(CMD_BYTE, rand_byte());
                end
            end else if (kind < 93) begin
                send_ticks($urandom_range(6, 1));
            end else begin
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++) begin
                    send_item(CMD_BYTE, lead_byte());
                end
            end
        end
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin : result_sink
        int   stall_left;
        int   hold_left;
        int   mode_left;
        bit   calm;
        logic next_ready;
        stall_left = 0;
        hold_left  = 0;
        mode_left  = 0;
        calm       = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                calm      = ($urandom_range(3) == 0);
                mode_left = $urandom_range(300, 50);
            end
            mode_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                next_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                next_ready = 1'b0;
                stall_left--;
            end else begin
                stall_left = calm ? 0 : pick_gap();
                next_ready = (stall_left == 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
            res_if.ready <= next_ready;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [TIMER_W-1:0] phase_timeouts[NUM_PHASES];
        phase_timeouts = '{16'd0, 16'd3, 16'd30, TIMEOUT_MAX, 16'd1, 16'd100};
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.command <= CMD_BYTE;
        rx_if.rx_byte <= '0;
        timeout_now    = IDLE_TIMEOUT_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // headers at both frame id extremes
        send_header(8'h55, 8'hFF);
        send_header(8'hAA, 8'h00);
        // responses: all ones, first byte zero with a bad check, second byte zero
        send_response({8{8'hFF}}, 1'b1);
        send_response(64'h0706050403020100, 1'b0);
        send_response(64'hFEDCBA987654005A, 1'b1);
        // ticks with no frame open, then a frame cut off at the reset timeout
        send_ticks(2);
        send_item(CMD_BYTE, 8'h3C);
        send_item(CMD_BYTE, 8'h00);
        send_ticks(int'(IDLE_TIMEOUT_RST) + 2);

        // zero timeout drops a frame on its first tick
        set_timeout('0);
        send_item(CMD_BYTE, 8'h81);
        send_ticks(1);

        // largest timeout keeps the frame open, a lowered one drops it on the next tick
        set_timeout(TIMEOUT_MAX);
        send_item(CMD_BYTE, 8'h12);
        send_item(CMD_BYTE, 8'h34);
        send_ticks(MAX_TO_TICKS);
        set_timeout(16'd10);
        send_ticks(1);
        send_item(CMD_BYTE, 8'h00);
        send_ticks(1);

        // random phases over several timeout settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_timeout(phase_timeouts[p]);
            if (p == 2) begin
                hold_request = 1'b1;
            end
            if (p == 3) begin
                random_phase(RANDOM_ITEMS / (2 * NUM_PHASES));
                wait_drained();
                random_phase(RANDOM_ITEMS / (2 * NUM_PHASES));
            end else begin
                random_phase(RANDOM_ITEMS / NUM_PHASES);
            end
        end

        wait_drained();
        $display("summary: %0d transfers, %0d headers, %0d responses, %0d cut-off frames",
                 items_sent, headers_sent, responses_sent, partials_sent);
        $display("summary: %0d timeout settings incl. 0 and max, one long result hold-off",
                 settings_used);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("watchdog: run limit reached");
        $display("tb: failure");
        $finish;
    end

endmodule
